### src/dcrc_pkg.sv
`timescale 1ns / 1ps
// Package for the double-couple radiation coefficient block.
// Holds payload types, CORDIC lane types, arctangent table, angle reduction and Q.30 product.
package dcrc_pkg;

    localparam int COEF_WIDTH      = 16;
    localparam int TRIG_STAGES_DEF = 16;
    localparam int ATAN_COUNT      = 24;
    localparam int XW              = 34;   // CORDIC x/y width
    localparam int ZW              = 32;   // CORDIC residual angle width
    localparam int QW              = 33;   // Q.30 working value width

    localparam logic signed [XW-1:0] GAIN_Q30  = XW'(652032866);
    localparam logic signed [17:0]   FULL_TURN = 18'sd36000;
    localparam logic signed [17:0]   HALF_TURN = 18'sd18000;
    localparam logic signed [17:0]   QTR_TURN  = 18'sd9000;
    localparam logic signed [17:0]   WRAP2_LIM = 18'sd54000;

    typedef logic signed [QW-1:0] t_q;

    typedef struct packed {
        logic        [15:0] strike_angle;
        logic        [13:0] dip_angle;
        logic signed [15:0] rake_angle;
    } t_in;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] vert_45;
        logic signed [COEF_WIDTH-1:0] vert_dd;
        logic signed [COEF_WIDTH-1:0] tang_dd;
        logic signed [COEF_WIDTH-1:0] vert_ss;
        logic signed [COEF_WIDTH-1:0] tang_ss;
    } t_out;

    // one angle in flight through the rotator
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } t_lane;

    // lane 2: strike, lane 1: dip, lane 0: rake
    typedef struct packed {
        t_lane [2:0] lane;
    } t_cstage;

    // terms handed from the product pipeline to the output stage
    typedef struct packed {
        t_q v45;
        t_q vdd;
        t_q tdd;
        t_q u1;
        t_q u2;
        t_q u3;
        t_q u4;
    } t_terms;

    typedef struct packed {
        logic signed [15:0] ang;
        logic               flip;
    } t_red;

    // arctangent of 2^-i in units of 1/6553600 degree
    function automatic logic signed [ZW-1:0] dcrc_atan(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466765;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183347;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

    // wrap to [-180, 180) degrees, then fold into [-90, 90] with a sign flag
    function automatic t_red dcrc_reduce(input logic signed [17:0] a);
        logic signed [17:0] w;
        t_red r;
        if (a >= WRAP2_LIM) begin
            w = a - FULL_TURN - FULL_TURN;
        end else if (a >= HALF_TURN) begin
            w = a - FULL_TURN;
        end else if (a < -HALF_TURN) begin
            w = a + FULL_TURN;
        end else begin
            w = a;
        end
        r.flip = 1'b1;
        if (w > QTR_TURN) begin
            w = w - HALF_TURN;
        end else if (w < -QTR_TURN) begin
            w = w + HALF_TURN;
        end else begin
            r.flip = 1'b0;
        end
        r.ang = w[15:0];
        return r;
    endfunction

    // Q.30 product with round half up
    function automatic t_q dcrc_qmul(input t_q a, input t_q b);
        logic signed [2*QW-1:0] p;
        p = (2*QW)'(a) * (2*QW)'(b);
        p = p + (2*QW)'(536870912);
        return p[QW+29:30];
    endfunction

endpackage

### src/dcrc_cordic_cell.sv
`timescale 1ns / 1ps
// One rotation-mode CORDIC cell, three angles side by side.
// Depends on dcrc_pkg for lane types and the arctangent table.
module dcrc_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  dcrc_pkg::t_cstage i_data,
    output logic             o_valid,
    output dcrc_pkg::t_cstage o_data
);
    import dcrc_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_K = dcrc_atan(SHIFT);

    logic     r_valid;
    t_cstage  r_data;
    t_cstage  n_data;

    // micro-rotation toward zero residual angle
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_data.lane[k].flip = i_data.lane[k].flip;
            if (i_data.lane[k].z >= 0) begin
                n_data.lane[k].x = i_data.lane[k].x - (i_data.lane[k].y >>> SHIFT);
                n_data.lane[k].y = i_data.lane[k].y + (i_data.lane[k].x >>> SHIFT);
                n_data.lane[k].z = i_data.lane[k].z - ATAN_K;
            end else begin
                n_data.lane[k].x = i_data.lane[k].x + (i_data.lane[k].y >>> SHIFT);
                n_data.lane[k].y = i_data.lane[k].y - (i_data.lane[k].x >>> SHIFT);
                n_data.lane[k].z = i_data.lane[k].z + ATAN_K;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### src/dcrc_products.sv
`timescale 1ns / 1ps
// Three-stage product pipeline: double-angle terms and the partial coefficient products.
// Depends on dcrc_pkg for the Q.30 multiply and stage types.
module dcrc_products (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  dcrc_pkg::t_cstage i_data,
    output logic              o_valid,
    output dcrc_pkg::t_terms  o_terms
);
    import dcrc_pkg::*;

    // stage 1 registers
    logic r_v1;
    t_q   r_sd, r_cd, r_sr, r_cr;
    t_q   r_sscs, r_cscs, r_ssss, r_sdcd, r_cdcd, r_sdsd;
    t_q   r_sssr, r_cscr, r_cssr, r_sscr;
    // stage 2 registers
    logic r_v2;
    t_q   r_t1, r_t2, r_t3, r_t4, r_v45;
    t_q   r_ss2cr, r_cs2sr, r_cs2cr, r_ss2sr, r_sd2, r_sd2h;
    // stage 3 registers
    logic   r_v3;
    t_terms r_terms;

    t_q ss, cs, sd, cd, sr, cr;
    t_q ss2, cs2, cd2;

    // sign-fold each rotator output
    always_comb begin
        ss = i_data.lane[2].flip ? -QW'(i_data.lane[2].y) : QW'(i_data.lane[2].y);
        cs = i_data.lane[2].flip ? -QW'(i_data.lane[2].x) : QW'(i_data.lane[2].x);
        sd = i_data.lane[1].flip ? -QW'(i_data.lane[1].y) : QW'(i_data.lane[1].y);
        cd = i_data.lane[1].flip ? -QW'(i_data.lane[1].x) : QW'(i_data.lane[1].x);
        sr = i_data.lane[0].flip ? -QW'(i_data.lane[0].y) : QW'(i_data.lane[0].y);
        cr = i_data.lane[0].flip ? -QW'(i_data.lane[0].x) : QW'(i_data.lane[0].x);
    end

    // double-angle terms from stage 1 products
    always_comb begin
        ss2 = r_sscs <<< 1;
        cs2 = r_cscs - r_ssss;
        cd2 = r_cdcd - r_sdsd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: squares and cross products of sines and cosines
            r_sd   <= sd;
            r_cd   <= cd;
            r_sr   <= sr;
            r_cr   <= cr;
            r_sscs <= dcrc_qmul(ss, cs);
            r_cscs <= dcrc_qmul(cs, cs);
            r_ssss <= dcrc_qmul(ss, ss);
            r_sdcd <= dcrc_qmul(sd, cd);
            r_cdcd <= dcrc_qmul(cd, cd);
            r_sdsd <= dcrc_qmul(sd, sd);
            r_sssr <= dcrc_qmul(ss, sr);
            r_cscr <= dcrc_qmul(cs, cr);
            r_cssr <= dcrc_qmul(cs, sr);
            r_sscr <= dcrc_qmul(ss, cr);
            // stage 2: dip-slip terms and second-level strike-slip products
            r_t1    <= dcrc_qmul(r_sssr, cd2);
            r_t2    <= dcrc_qmul(r_cscr, r_cd);
            r_t3    <= dcrc_qmul(r_cssr, cd2);
            r_t4    <= dcrc_qmul(r_sscr, r_cd);
            r_v45   <= dcrc_qmul(r_sr, r_sdcd);
            r_ss2cr <= dcrc_qmul(ss2, r_cr);
            r_cs2sr <= dcrc_qmul(cs2, r_sr);
            r_cs2cr <= dcrc_qmul(cs2, r_cr);
            r_ss2sr <= dcrc_qmul(ss2, r_sr);
            r_sd2   <= r_sd;
            r_sd2h  <= r_sdcd;
            // stage 3: dip-slip sums and last strike-slip products
            r_terms.v45 <= r_v45;
            r_terms.vdd <= r_t2 - r_t1;
            r_terms.tdd <= r_t3 + r_t4;
            r_terms.u1  <= dcrc_qmul(r_ss2cr, r_sd2);
            r_terms.u2  <= dcrc_qmul(r_cs2sr, r_sd2h);
            r_terms.u3  <= dcrc_qmul(r_cs2cr, r_sd2);
            r_terms.u4  <= dcrc_qmul(r_ss2sr, r_sd2h);
        end
    end

    assign o_valid = r_v3;
    assign o_terms = r_terms;

endmodule

### src/double_couple_radiation_coefs.sv
`timescale 1ns / 1ps
// Double-couple radiation coefficients: takes one (azimuth, dip, rake) transaction per cycle
// and returns five Q2.14 coefficients through a registered pipeline of angle reduction,
// one CORDIC cell per iteration, three product stages and an output register.
// Throughput is one transaction per cycle; the whole pipeline holds while the output is stalled.
// Depends on dcrc_pkg, dcrc_cordic_cell and dcrc_products.
module double_couple_radiation_coefs #(
    parameter int TRIG_STAGES = dcrc_pkg::TRIG_STAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dcrc_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dcrc_pkg::t_out o_out_data
);
    import dcrc_pkg::*;

    localparam int SH = 32 - COEF_WIDTH;
    localparam int OW = QW + 3;
    localparam logic signed [OW-1:0] RND    = (OW'(1) <<< SH) >>> 1;
    localparam logic signed [OW-1:0] SAT_HI = (OW'(1) <<< (COEF_WIDTH - 1)) - OW'(1);
    localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

    logic    en;
    logic    r_red_v;
    t_cstage r_red;
    t_red    red_s, red_d, red_r;

    logic    c_v [0:TRIG_STAGES];
    t_cstage c_d [0:TRIG_STAGES];

    logic    p_v;
    t_terms  p_t;

    logic    r_out_valid;
    t_out    r_out;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // angle reduction into the rotator's range
    always_comb begin
        red_s = dcrc_reduce($signed({2'b00, i_in_data.strike_angle}));
        red_d = dcrc_reduce($signed({4'b0000, i_in_data.dip_angle}));
        red_r = dcrc_reduce({{2{i_in_data.rake_angle[15]}}, i_in_data.rake_angle});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_v <= 1'b0;
        end else if (en) begin
            r_red_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_red.lane[2] <= '{x: GAIN_Q30, y: '0, z: {red_s.ang, 16'h0000}, flip: red_s.flip};
            r_red.lane[1] <= '{x: GAIN_Q30, y: '0, z: {red_d.ang, 16'h0000}, flip: red_d.flip};
            r_red.lane[0] <= '{x: GAIN_Q30, y: '0, z: {red_r.ang, 16'h0000}, flip: red_r.flip};
        end
    end

    assign c_v[0] = r_red_v;
    assign c_d[0] = r_red;

    // CORDIC cell chain
    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
        dcrc_cordic_cell #(
            .SHIFT(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(c_v[g]),
            .i_data (c_d[g]),
            .o_valid(c_v[g+1]),
            .o_data (c_d[g+1])
        );
    end

    dcrc_products u_prod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(c_v[TRIG_STAGES]),
        .i_data (c_d[TRIG_STAGES]),
        .o_valid(p_v),
        .o_terms(p_t)
    );

    // round half up and saturate to the output width
    function automatic logic signed [COEF_WIDTH-1:0] to_out(input logic signed [OW-1:0] v);
        logic signed [OW-1:0] r;
        r = (v + RND) >>> SH;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[COEF_WIDTH-1:0];
    endfunction

    // output register: strike-slip sums and final formatting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.vert_45 <= to_out(OW'(p_t.v45));
            r_out.vert_dd <= to_out(OW'(p_t.vdd));
            r_out.tang_dd <= to_out(OW'(p_t.tdd));
            r_out.vert_ss <= to_out(-OW'(p_t.u1) - OW'(p_t.u2));
            r_out.tang_ss <= to_out(OW'(p_t.u3) - OW'(p_t.u4));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_red) && $stable(r_red_v))
        else $error("reduction stage moved while stalled");

    a_v45_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.vert_45 <= COEF_WIDTH'((1 <<< (COEF_WIDTH - 3)) + 4)) &&
                        (o_out_data.vert_45 >= -COEF_WIDTH'((1 <<< (COEF_WIDTH - 3)) + 4)))
        else $error("45-degree coefficient out of range");

endmodule
